// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the fifo, scan-control and top-level RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every clock edge while reset is low.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that trig implies prop on the next edge while reset is low.
`define ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

// ----- hw/rtl/mfbs_pkg.sv -----
package mfbs_pkg;

   // Panel geometry
   localparam int LINE_PIXELS = 128;
   localparam int LINE_COUNT  = 128;
   localparam int ROW_BYTES   = 8;

   // Two bytes per pixel column, each pixel held for four bytes
   localparam int SCAN_COLS   = 2 * LINE_PIXELS;

   localparam int STORE_DEPTH = 512;
   localparam int STORE_AW    = 9;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 9;
   localparam int COL_W       = 9;
   localparam int LINE_W      = 8;
   localparam int ADDR_SUM_W  = 12;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [BYTE_W-1:0] OPCODE_RESET = 8'd44;
   localparam logic [WORD_W-1:0] DATA_FLAG    = 9'h100;
   localparam logic [2:0]        BYTE_MSB     = 3'd7;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Scan step handed from the address stage to the pixel stage
   typedef struct packed {
      logic       valid;
      logic       start;
      logic       even;
      logic       load;
      logic [2:0] bitpos;
      logic       done;
   } stage_type;

   typedef struct packed {
      logic              last;
      logic              done;
      logic [WORD_W-1:0] word;
   } rsp_entry_type;

endpackage

// ----- hw/rtl/mfbs_ram.sv -----
module mfbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mfbs_rsp_fifo.sv -----
module mfbs_rsp_fifo
   import mfbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_n,
   input  rsp_entry_type         push_e0,
   input  rsp_entry_type         push_e1,
   input  logic                  pop,
   output logic                  not_empty,
   output rsp_entry_type         head,
   output logic [FIFO_CNT_W-1:0] count
);

`include "assert_macros.svh"

   rsp_entry_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wp_ff, wp_in;
   logic [FIFO_PTR_W-1:0]   rp_ff, rp_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [FIFO_PTR_W-1:0]   wp_next;

   assign wp_next = wp_ff + FIFO_PTR_W'(1);

   always_comb begin
      wp_in    = wp_ff + FIFO_PTR_W'(push_n);
      rp_in    = pop ? rp_ff + FIFO_PTR_W'(1) : rp_ff;
      count_in = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wp_ff] <= push_e0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wp_next] <= push_e1;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rp_ff];
   assign count     = count_ff;

   `ASSERT_CLK(a_fifo_no_overflow, clock, reset,
      (count_ff + FIFO_CNT_W'(push_n) <= FIFO_CNT_W'(FIFO_DEPTH)),
      "response fifo overflow")
   `ASSERT_CLK(a_fifo_no_underflow, clock, reset, (!pop || count_ff != '0),
      "response fifo pop while empty")

endmodule

// ----- hw/rtl/mfbs_scan_ctrl.sv -----
module mfbs_scan_ctrl
   import mfbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_go,
   input  logic [1:0]          operation,
   input  logic [STORE_AW-1:0] write_address,
   input  logic [BYTE_W-1:0]   write_data,
   output logic                ram_we,
   output logic [STORE_AW-1:0] ram_addr,
   output logic [BYTE_W-1:0]   ram_wdata,
   output stage_type           stage
);

`include "assert_macros.svh"

   logic [COL_W-1:0]      col_ff, col_in;
   logic [LINE_W-1:0]     line_ff, line_in;
   logic                  busy_ff, busy_in;
   stage_type             stage_ff, stage_in;

   logic                  start_go;
   logic                  step_go;
   logic                  wrap;
   logic                  done;
   logic [COL_W:0]        col_inc;
   logic [LINE_W:0]       line_next;
   logic [ADDR_SUM_W-1:0] addr_sum;

   // Byte under the current column: row pair times row bytes plus column / 32
   assign addr_sum = ADDR_SUM_W'(line_ff[LINE_W-1:1]) * ADDR_SUM_W'(ROW_BYTES)
                   + ADDR_SUM_W'(col_ff[COL_W-1:5]);

   always_comb begin
      ram_we    = 1'b0;
      start_go  = 1'b0;
      step_go   = 1'b0;
      ram_wdata = write_data;
      if (req_go) begin
         unique case (operation)
            OP_WRITE: ram_we = 1'b1;
            OP_START: start_go = !busy_ff;
            OP_TICK:  step_go = busy_ff;
            default:  ;
         endcase
      end
      step_go  = step_go | start_go;
      ram_addr = step_go ? addr_sum[STORE_AW-1:0] : write_address;

      col_inc   = {1'b0, col_ff} + (COL_W+1)'(1);
      wrap      = col_inc >= (COL_W+1)'(SCAN_COLS);
      line_next = wrap ? {1'b0, line_ff} + (LINE_W+1)'(1) : {1'b0, line_ff};
      done      = line_next >= (LINE_W+1)'(LINE_COUNT);

      col_in  = col_ff;
      line_in = line_ff;
      busy_in = busy_ff;
      if (start_go) begin
         busy_in = 1'b1;
      end
      if (step_go) begin
         col_in  = (wrap || done) ? '0 : col_inc[COL_W-1:0];
         line_in = done ? '0 : line_next[LINE_W-1:0];
         if (done) begin
            busy_in = 1'b0;
         end
      end

      stage_in.valid  = step_go;
      stage_in.start  = start_go;
      stage_in.even   = !line_ff[0];
      stage_in.load   = line_ff[0] && (col_ff[1:0] == 2'd0);
      stage_in.bitpos = col_ff[4:2];
      stage_in.done   = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         line_ff        <= '0;
         busy_ff        <= 1'b0;
         stage_ff.valid <= 1'b0;
      end else begin
         col_ff         <= col_in;
         line_ff        <= line_in;
         busy_ff        <= busy_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.start  <= stage_in.start;
      stage_ff.even   <= stage_in.even;
      stage_ff.load   <= stage_in.load;
      stage_ff.bitpos <= stage_in.bitpos;
      stage_ff.done   <= stage_in.done;
   end

   assign stage = stage_ff;

   `ASSERT_CLK(a_idle_rewound, clock, reset,
      (busy_ff || (col_ff == '0 && line_ff == '0)),
      "scan counters not rewound while idle")
   `ASSERT_NEXT(a_start_sets_busy, clock, reset, start_go, busy_ff,
      "frame start did not set busy")

endmodule

// ----- hw/rtl/mono_framebuffer_lcd_scanout_unit.sv -----
// Mono framebuffer scanout to a 9-bit SPI LCD.
// Request channel (req_*): tuser carries the operation (write byte, start
// frame, transmit-ready tick); tdata carries address and byte for writes.
// Response channel (rsp_*): one 9-bit SPI word per transfer, bit 8 set for
// data; tuser flags the last word of a frame, tlast the final response of
// a request. A start gives two responses (RAM-write opcode, first data
// word), a tick while busy gives one, writes and ignored requests none.
// csr_wr_en/csr_wr_data load the RAM-write opcode (44 after reset).
// The first response passes the registered store read and stage, then
// the response fifo. Throughput: one request per cycle while the fifo
// has room; the single port of the frame store serves either the write
// or the scan read of the request, and the fifo sets the only backpressure.
// When rsp_tready is low the 4-entry response fifo absorbs in-flight work
// and req_tready drops once fewer than two free slots remain.
// Reset clears counters, busy, held pixel level and the fifo; the frame
// store is not cleared and needs no sweep.
module mono_framebuffer_lcd_scanout_unit
   import mfbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [8:0] write_address, [16:9] write_data, rest zero
   input  logic [1:0]  req_tuser,  // [1:0] operation
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [8:0] spi_word, rest zero
   output logic        rsp_tuser,  // [0] frame_done
   output logic        rsp_tlast,
   // opcode register
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

`include "assert_macros.svh"

   logic [BYTE_W-1:0]     opcode_ff, opcode_in;
   logic                  held_ff, held_in;

   logic                  req_go;
   logic                  ram_we;
   logic [STORE_AW-1:0]   ram_addr;
   logic [BYTE_W-1:0]     ram_wdata;
   logic [BYTE_W-1:0]     ram_rdata;
   stage_type             stage;

   logic [1:0]            push_n;
   rsp_entry_type         push_e0;
   rsp_entry_type         push_e1;
   rsp_entry_type         head;
   logic                  fifo_ne;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [FIFO_CNT_W-1:0] fill_sum;
   logic [WORD_W-1:0]     data_word;

   // Responses already owed by the pixel stage count against fifo room
   assign fill_sum   = fifo_count + FIFO_CNT_W'(push_n);
   assign req_tready = fill_sum <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign req_go     = req_tvalid && req_tready;

   mfbs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   mfbs_scan_ctrl u_scan_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_go        (req_go),
      .operation     (req_tuser),
      .write_address (req_tdata[8:0]),
      .write_data    (req_tdata[16:9]),
      .ram_we        (ram_we),
      .ram_addr      (ram_addr),
      .ram_wdata     (ram_wdata),
      .stage         (stage)
   );

   // Pixel stage: even lines are black, odd lines sample a new pixel every
   // fourth byte and hold it in between.
   always_comb begin
      held_in = held_ff;
      if (stage.valid) begin
         if (stage.even) begin
            held_in = 1'b0;
         end else if (stage.load) begin
            held_in = ram_rdata[BYTE_MSB - stage.bitpos];
         end
      end
      data_word = DATA_FLAG | {1'b0, {BYTE_W{held_in}}};

      opcode_in = csr_wr_en ? csr_wr_data : opcode_ff;

      push_n  = 2'd0;
      push_e0 = '{last: 1'b1, done: stage.done, word: data_word};
      push_e1 = '{last: 1'b1, done: stage.done, word: data_word};
      if (stage.valid) begin
         if (stage.start) begin
            push_n  = 2'd2;
            push_e0 = '{last: 1'b0, done: 1'b0, word: {1'b0, opcode_ff}};
         end else begin
            push_n = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff <= OPCODE_RESET;
         held_ff   <= 1'b0;
      end else begin
         opcode_ff <= opcode_in;
         held_ff   <= held_in;
      end
   end

   mfbs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_e0   (push_e0),
      .push_e1   (push_e1),
      .pop       (rsp_tvalid && rsp_tready),
      .not_empty (fifo_ne),
      .head      (head),
      .count     (fifo_count)
   );

   assign rsp_tvalid = fifo_ne;
   assign rsp_tdata  = {{(16 - WORD_W){1'b0}}, head.word};
   assign rsp_tuser  = head.done;
   assign rsp_tlast  = head.last;

   `ASSERT_NEXT(a_accept_room, clock, reset, req_go,
      (fifo_count + FIFO_CNT_W'(push_n) <= FIFO_CNT_W'(FIFO_DEPTH)),
      "request taken without fifo room for its responses")

endmodule
